// ===== src/drum_chord_sequence_to_key_unit_assert.svh =====
// Assertion macros used by the port-level checker file
`ifndef DRUM_CHORD_SEQUENCE_TO_KEY_UNIT_ASSERT_SVH
`define DRUM_CHORD_SEQUENCE_TO_KEY_UNIT_ASSERT_SVH

`define DCK_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define DCK_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/dck_pkg.sv =====
// ----------------------------------------------------------------------------
// dck_pkg
// Shared types, constants and keymap ROM for the drum chord key unit.
// ----------------------------------------------------------------------------
package dck_pkg;

   localparam int NumPadsDef    = 9;
   localparam int MaxStrokesDef = 4;
   localparam int MapEntriesDef = 61;
   localparam int PadRows       = 9;
   localparam int RomRows       = 64;

   localparam logic [7:0] StatusNoteOn = 8'h90;
   localparam logic [7:0] StatusMask   = 8'hf0;
   localparam logic [7:0] ByteTick     = 8'hf8;

   localparam logic [6:0] StrokeThrRst = 7'd5;
   localparam logic [7:0] HitThrRst    = 8'd15;
   localparam logic [7:0] TickLimRst   = 8'd5;

   localparam logic [1:0] RegStrokeThr = 2'd0;
   localparam logic [1:0] RegHitThr    = 2'd1;
   localparam logic [1:0] RegTickLim   = 2'd2;

   localparam logic [9:0] MBd  = 10'h001;
   localparam logic [9:0] MHh  = 10'h002;
   localparam logic [9:0] MHhc = 10'h004;
   localparam logic [9:0] MCr  = 10'h008;
   localparam logic [9:0] MSn  = 10'h010;
   localparam logic [9:0] MSt  = 10'h020;
   localparam logic [9:0] MRi  = 10'h040;
   localparam logic [9:0] MFt  = 10'h080;
   localparam logic [9:0] MHf  = 10'h100;
   localparam logic [9:0] MBad = 10'h200;

   typedef enum logic [1:0] {
      PH_STATUS,
      PH_KEY,
      PH_VEL
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_SCAN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        len2;
      logic [9:0]  chord0;
      logic [9:0]  chord1;
      logic [15:0] key;
      logic        shift;
   } rom_row_type;

   typedef struct packed {
      logic start_tick;
      logic scan_clear;
      logic scan_step;
      logic close;
   } dck_cmd_type;

   typedef struct packed {
      logic close_due;
      logic scan_hit;
      logic scan_last;
      logic overflow;
   } dck_sts_type;

   function automatic logic [7:0] pad_key(input int i);
      logic [7:0] k;
      case (i)
         0: k = 8'h21;
         1: k = 8'h2e;
         2: k = 8'h2a;
         3: k = 8'h31;
         4: k = 8'h28;
         5: k = 8'h30;
         6: k = 8'h3b;
         7: k = 8'h2f;
         8: k = 8'h2c;
         default: k = 8'h00;
      endcase
      return k;
   endfunction

   function automatic rom_row_type pair_row(input logic [9:0] ch, input logic [7:0] lo,
                                            input logic [7:0] up, input logic upper);
      rom_row_type r;
      r.len2   = upper;
      r.chord0 = ch;
      r.chord1 = upper ? ch : 10'h000;
      r.key    = {8'h00, upper ? up : lo};
      r.shift  = upper;
      return r;
   endfunction

   function automatic rom_row_type one_row(input logic [9:0] ch, input logic [15:0] k,
                                           input logic s);
      rom_row_type r;
      r.len2   = 1'b0;
      r.chord0 = ch;
      r.chord1 = 10'h000;
      r.key    = k;
      r.shift  = s;
      return r;
   endfunction

   function automatic logic [9:0] pair_chord(input logic [4:0] p);
      logic [9:0] c;
      case (p)
         5'd0:  c = MRi;
         5'd1:  c = MBd | MSn;
         5'd2:  c = MCr | MSn;
         5'd3:  c = MCr | MSt;
         5'd4:  c = MSn;
         5'd5:  c = MBd | MHf;
         5'd6:  c = MBd | MFt;
         5'd7:  c = MSn | MSt;
         5'd8:  c = MSt;
         5'd9:  c = MFt | MHf;
         5'd10: c = MHh | MFt;
         5'd11: c = MBd | MSt;
         5'd12: c = MHh | MSn;
         5'd13: c = MFt;
         5'd14: c = MCr;
         5'd15: c = MSn | MFt;
         5'd16: c = MBd | MSn | MHf;
         5'd17: c = MHf;
         5'd18: c = MCr | MRi;
         5'd19: c = MHh;
         5'd20: c = MHh | MCr;
         5'd21: c = MBd | MCr | MRi;
         5'd22: c = MBd | MHh | MRi;
         5'd23: c = MRi | MHf;
         5'd24: c = MBd | MSn | MFt;
         5'd25: c = MBd | MSn | MSt;
         default: c = 10'h000;
      endcase
      return c;
   endfunction

   // A row means empty when chord0 is zero.
   function automatic rom_row_type keymap(input logic [5:0] a);
      rom_row_type r;
      logic [7:0]  lo;
      r = '0;
      lo = 8'h61 + {3'd0, a[5:1]};
      if (a < 6'd52) begin
         r = pair_row(pair_chord(a[5:1]), lo, lo - 8'h20, a[0]);
      end else begin
         case (a)
            6'd52: r = one_row(MBd, 16'h0020, 1'b0);
            6'd53: r = one_row(MBd | MCr, 16'hff08, 1'b0);
            6'd54: r = one_row(MSn | MRi, 16'h002e, 1'b0);
            6'd55: r = one_row(MHh | MRi, 16'h002c, 1'b0);
            6'd56: r = one_row(MBd | MRi, 16'h0021, 1'b1);
            6'd57: r = one_row(MSt | MRi, 16'h003b, 1'b0);
            6'd58: r = one_row(MBd | MSn | MRi, 16'hff0d, 1'b0);
            default: r = '0;
         endcase
      end
      return r;
   endfunction

   function automatic logic [9:0] merge_hats(input logic [9:0] m);
      logic [9:0] r;
      if (m[1] && m[2])
         r = MBad;
      else if (m[2])
         r = (m & ~MHhc) | MHh;
      else
         r = m;
      return r;
   endfunction

endpackage

// ===== src/dck_ctrl.sv =====
// ----------------------------------------------------------------------------
// dck_ctrl
// Sequencer: tick handling, keymap walk and result hand-off.
// ----------------------------------------------------------------------------
module dck_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick_req,
   input  dck_pkg::dck_sts_type sts,
   input  logic                 out_taken,
   output dck_pkg::dck_cmd_type cmd,
   output logic                 busy,
   output logic                 out_valid
);
   import dck_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tick_req) state_in = ST_TICK;
         end
         ST_TICK: begin
            if (sts.close_due) state_in = sts.overflow ? ST_OUT : ST_SCAN;
            else state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (sts.scan_hit || sts.scan_last) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_taken) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      out_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.start_tick = tick_req;
         end
         ST_TICK: begin
            cmd.scan_clear = 1'b1;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            cmd.close = out_taken;
         end
         default: busy = 1'b1;
      endcase
   end

endmodule

// ===== src/dck_dpath.sv =====
// ----------------------------------------------------------------------------
// dck_dpath
// MIDI parser, pad levels, stroke store, tick counter and keymap matcher.
// ----------------------------------------------------------------------------
module dck_dpath #(
   parameter int NUM_PADS    = dck_pkg::NumPadsDef,
   parameter int MAX_STROKES = dck_pkg::MaxStrokesDef,
   parameter int MAP_ENTRIES = dck_pkg::MapEntriesDef
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_valid,
   input  logic [7:0]           midi_byte,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [7:0]           csr_wdata,
   input  dck_pkg::dck_cmd_type cmd,
   output dck_pkg::dck_sts_type sts,
   output logic                 tick_req,
   output logic [23:0]          rsp_data
);
   import dck_pkg::*;

   localparam int SW = $clog2(MAX_STROKES + 1);
   localparam int IW = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
   localparam int NP = (NUM_PADS < PadRows) ? NUM_PADS : PadRows;
   localparam int ME = (MAP_ENTRIES < RomRows) ? MAP_ENTRIES : RomRows;

   logic [6:0]  stroke_thr_ff;
   logic [7:0]  hit_thr_ff, tick_lim_ff;
   phase_type   phase_ff;
   logic [7:0]  held_key_ff;
   logic [7:0]  level_ff [NUM_PADS];
   logic [7:0]  tick_cnt_ff;
   logic [9:0]  mask_ff [MAX_STROKES];
   logic [SW-1:0] scount_ff;
   logic        ovf_ff;
   logic        due_ff;
   logic [5:0]  addr_ff;
   logic        found_ff;
   logic [5:0]  idx_ff;
   logic [15:0] key_ff;
   logic        shift_ff;

   logic        pending;
   logic [9:0]  chord_m;
   logic [7:0]  tick_base;
   logic        scount_nz_new;
   rom_row_type row;
   logic        hit;
   logic [7:0]  thr8;

   assign thr8     = {1'b0, stroke_thr_ff};
   assign tick_req = byte_valid && (phase_ff == PH_STATUS) && (midi_byte == ByteTick);

   always_comb begin
      pending = 1'b0;
      chord_m = '0;
      for (int i = 0; i < NP; i++) begin
         if ((level_ff[i] >> 1) < thr8 && level_ff[i] >= thr8) pending = 1'b1;
         if (level_ff[i] >= thr8) chord_m[i] = 1'b1;
      end
   end

   assign tick_base     = (pending && scount_ff == '0) ? 8'd0 : tick_cnt_ff;
   assign scount_nz_new = pending || (scount_ff != '0);

   assign row = keymap(addr_ff);
   always_comb begin
      hit = (row.chord0 != '0) && (row.len2 ? (scount_ff == SW'(2)) : (scount_ff == SW'(1)))
            && (merge_hats(mask_ff[0]) == row.chord0);
      if (row.len2 && MAX_STROKES > 1)
         hit = hit && (merge_hats(mask_ff[IW'(1)]) == row.chord1);
   end

   assign sts.close_due = due_ff;
   assign sts.scan_hit  = hit;
   assign sts.scan_last = (addr_ff == 6'(ME - 1));
   assign sts.overflow  = ovf_ff;
   assign rsp_data      = {shift_ff, key_ff, idx_ff, found_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         stroke_thr_ff <= StrokeThrRst;
         hit_thr_ff    <= HitThrRst;
         tick_lim_ff   <= TickLimRst;
         phase_ff      <= PH_STATUS;
         held_key_ff   <= '0;
         tick_cnt_ff   <= '0;
         scount_ff     <= '0;
         ovf_ff        <= 1'b0;
         due_ff        <= 1'b0;
         for (int i = 0; i < NUM_PADS; i++) level_ff[i] <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               RegStrokeThr: stroke_thr_ff <= csr_wdata[6:0];
               RegHitThr:    hit_thr_ff    <= csr_wdata;
               RegTickLim:   tick_lim_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (byte_valid) begin
            case (phase_ff)
               PH_KEY: begin
                  held_key_ff <= midi_byte;
                  phase_ff    <= PH_VEL;
               end
               PH_VEL: begin
                  phase_ff <= PH_STATUS;
                  if (midi_byte >= hit_thr_ff) begin
                     for (int i = NP - 1; i >= 0; i--)
                        if (pad_key(i) == held_key_ff) level_ff[i] <= midi_byte;
                  end
               end
               default: begin
                  phase_ff <= ((midi_byte & StatusMask) == StatusNoteOn) ? PH_KEY : PH_STATUS;
               end
            endcase
         end
         if (cmd.start_tick) begin
            if (pending) begin
               if (scount_ff < SW'(MAX_STROKES)) begin
                  mask_ff[scount_ff[IW-1:0]] <= chord_m;
                  scount_ff <= scount_ff + SW'(1);
               end else begin
                  ovf_ff <= 1'b1;
               end
               for (int i = 0; i < NUM_PADS; i++) level_ff[i] <= '0;
            end else begin
               for (int i = 0; i < NUM_PADS; i++) level_ff[i] <= level_ff[i] >> 1;
            end
            tick_cnt_ff <= tick_base + 8'd1;
            due_ff <= (tick_base > tick_lim_ff) && scount_nz_new;
         end
         if (cmd.scan_clear) begin
            addr_ff  <= '0;
            found_ff <= 1'b0;
            idx_ff   <= '0;
            key_ff   <= '0;
            shift_ff <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (hit) begin
               found_ff <= 1'b1;
               idx_ff   <= addr_ff;
               key_ff   <= row.key;
               shift_ff <= row.shift;
            end
            addr_ff <= addr_ff + 6'd1;
         end
         if (cmd.close) begin
            scount_ff   <= '0;
            ovf_ff      <= 1'b0;
            tick_cnt_ff <= '0;
            due_ff      <= 1'b0;
            for (int i = 0; i < NUM_PADS; i++) level_ff[i] <= '0;
         end
      end
   end

endmodule

// ===== src/drum_chord_sequence_to_key_unit.sv =====
// ----------------------------------------------------------------------------
// drum_chord_sequence_to_key_unit
// Turns a MIDI drum stream into key codes by chord sequence lookup.
// ----------------------------------------------------------------------------
// A tick also holds off the next byte while the unit checks whether the tick
// closes a sentence and clears the previous lookup result. A tick that closes
// a sentence then walks the keymap ROM one row per cycle (up to MAP_ENTRIES
// rows, at most 64, 61 by default) and holds the result beat until it is
// taken; no byte is accepted during that walk or while the result waits.
// An overlong sentence skips the walk.
module drum_chord_sequence_to_key_unit #(
   parameter int NUM_PADS    = dck_pkg::NumPadsDef,
   parameter int MAX_STROKES = dck_pkg::MaxStrokesDef,
   parameter int MAP_ENTRIES = dck_pkg::MapEntriesDef
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // midi_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // found, entry_index[6], keysym[16], shift
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);
   import dck_pkg::*;

   dck_cmd_type cmd;
   dck_sts_type sts;
   logic        busy, tick_req, byte_valid;

   assign req_tready = !busy;
   assign byte_valid = req_tvalid && req_tready;

   dck_ctrl u_ctrl (
      .clock(clock), .reset(reset), .tick_req(tick_req), .sts(sts),
      .out_taken(rsp_tready), .cmd(cmd), .busy(busy), .out_valid(rsp_tvalid)
   );

   dck_dpath #(
      .NUM_PADS(NUM_PADS), .MAX_STROKES(MAX_STROKES), .MAP_ENTRIES(MAP_ENTRIES)
   ) u_dpath (
      .clock(clock), .reset(reset), .byte_valid(byte_valid), .midi_byte(req_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .cmd(cmd), .sts(sts), .tick_req(tick_req), .rsp_data(rsp_tdata)
   );

endmodule

// ===== src/drum_chord_sequence_to_key_unit_checker.sv =====
// ----------------------------------------------------------------------------
// drum_chord_sequence_to_key_unit_checker
// Port-level checks for the drum chord key unit.
// ----------------------------------------------------------------------------
`include "drum_chord_sequence_to_key_unit_assert.svh"

module drum_chord_sequence_to_key_unit_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata
);
   `DCK_ASSERT_IMPL(a_no_req_while_rsp, clock, reset, rsp_tvalid |-> !req_tready, "ready during result")
   `DCK_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result beat dropped")
   `DCK_ASSERT_IMPL(a_unknown_zero, clock, reset, rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[23:1] == 23'd0, "unknown not zero")
   `DCK_ASSERT_NORST(a_reset_idle, clock, $past(reset) |-> !rsp_tvalid, "result after reset")
endmodule

bind drum_chord_sequence_to_key_unit drum_chord_sequence_to_key_unit_checker u_chk (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
